[sv/assert_macros.svh]
// Assertion macros used by the checker file tirb_chk.sv.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition implies another one on the same clock edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/tirb_pkg.sv]
// ----------------------------------------------------------------------------
// tirb_pkg
// Types and constants of the timer and interrupt register block.
// ----------------------------------------------------------------------------
`default_nettype none

package tirb_pkg;

  // Item kinds
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ASSERT = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Register offsets
  localparam logic [6:0] OFF_RSV00 = 7'h00;
  localparam logic [6:0] OFF_IMR   = 7'h04;
  localparam logic [6:0] OFF_RSV05 = 7'h05;
  localparam logic [6:0] OFF_IFR   = 7'h06;
  localparam logic [6:0] OFF_PMST  = 7'h07;
  localparam logic [6:0] OFF_TIM   = 7'h24;
  localparam logic [6:0] OFF_PRD   = 7'h25;
  localparam logic [6:0] OFF_TCR   = 7'h26;
  localparam logic [6:0] OFF_RSV28 = 7'h28;
  localparam logic [6:0] OFF_RSV29 = 7'h29;
  localparam logic [6:0] OFF_RSV2A = 7'h2a;
  localparam logic [6:0] OFF_RSV37 = 7'h37;

  typedef struct packed {
    cmd_t        cmd;
    logic [3:0]  irq_line;
    logic [6:0]  reg_offset;
    logic [15:0] write_data;
    logic        int_disable;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        reg_unknown;
    logic        int_taken;
    logic [3:0]  int_number;
    logic [15:0] int_vector;
  } out_item_t;

  // Lowest pending flag
  typedef struct packed {
    logic       found;
    logic [3:0] idx;
  } prio_t;

endpackage

`default_nettype wire

[sv/timer_interrupt_register_block.sv]
// ----------------------------------------------------------------------------
// timer_interrupt_register_block
// Prescaled down-counter timer and interrupt flag block with register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one item per handshake: a timer tick, an
//   interrupt line assertion, a register write or a register read, together
//   with the core's interrupt disable bit.
//   out_valid/out_ready/out_data return exactly one result item per input
//   item, in order: read data, unknown-offset flag and the taken interrupt
//   (number and vector address).
//   Order: an accepted item waits in the input register, is executed as it
//   moves into the output register, and its result is taken from there.
//   Throughput: one item per cycle while the receiver takes results; the state
//   update is one pass through the command decode and the lowest-flag priority encoder.
//   Reset (rst_n low at a clock edge) clears all registers, flags and both
//   pipeline stages.
//   When the receiver stalls, the result holds in the output register and the
//   next item waits in the input register; then in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_interrupt_register_block
  import tirb_pkg::*;
#(
  parameter int unsigned TIMER_IRQ_BIT = 3
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  logic      inq_v_r;
  in_item_t  inq_r;
  logic      outq_v_r;
  out_item_t outq_r;
  logic      adv;
  out_item_t res;

  // advance the held item when the output register is free or draining
  assign adv      = inq_v_r && (!outq_v_r || out_ready);
  assign in_ready = !inq_v_r || adv;

  tirb_core #(
    .TIMER_IRQ_BIT (TIMER_IRQ_BIT)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (adv),
    .item  (inq_r),
    .res   (res)
  );

  // input register: hold the item until the core executes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
    end else if (in_ready) begin
      inq_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_r <= in_data;
    end
  end

  // result register: load on execute, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outq_v_r <= 1'b0;
    end else if (adv) begin
      outq_v_r <= 1'b1;
    end else if (out_ready) begin
      outq_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outq_r <= res;
    end
  end

  assign out_valid = outq_v_r;
  assign out_data  = outq_r;

endmodule

`default_nettype wire

[sv/tirb_prio.sv]
// ----------------------------------------------------------------------------
// tirb_prio
// Find the lowest set bit of the pending interrupt flags.
// ----------------------------------------------------------------------------
`default_nettype none

module tirb_prio
  import tirb_pkg::*;
(
  input  wire logic [15:0] flags,
  output prio_t            sel
);

  always_comb begin
    sel = '0;
    // scan from the top so the lowest set bit wins
    for (int i = 15; i >= 0; i--) begin
      if (flags[i]) begin
        sel.found = 1'b1;
        sel.idx   = 4'(i);
      end
    end
  end

endmodule

`default_nettype wire

[sv/tirb_core.sv]
// ----------------------------------------------------------------------------
// tirb_core
// Register state, item decode and interrupt take for one item per cycle while exec is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tirb_core
  import tirb_pkg::*;
#(
  parameter int unsigned TIMER_IRQ_BIT = 3
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     exec,
  input  wire in_item_t item,
  output out_item_t     res
);

  logic [15:0] mask_r, mask_nxt;
  logic [15:0] flag_r, flag_nxt, flag_cmd;
  logic [4:0]  base_r, base_nxt;
  logic [6:0]  mode_r, mode_nxt;
  logic [3:0]  psc_r, psc_nxt;
  logic [3:0]  reload_r, reload_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  logic [15:0] period_r, period_nxt;
  logic [15:0] rd;
  logic        unk;
  prio_t       sel;

  tirb_prio u_prio (
    .flags (flag_cmd),
    .sel   (sel)
  );

  // command effect
  always_comb begin
    mask_nxt   = mask_r;
    flag_cmd   = flag_r;
    base_nxt   = base_r;
    mode_nxt   = mode_r;
    psc_nxt    = psc_r;
    reload_nxt = reload_r;
    tcnt_nxt   = tcnt_r;
    period_nxt = period_r;
    rd         = '0;
    unk        = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (psc_r == 4'd0) begin
          psc_nxt = reload_r;
          if (tcnt_r == 16'd0) begin
            tcnt_nxt = period_r;
            if (mask_r[TIMER_IRQ_BIT]) begin
              flag_cmd[TIMER_IRQ_BIT] = 1'b1;
            end
          end else begin
            tcnt_nxt = tcnt_r - 16'd1;
          end
        end else begin
          psc_nxt = psc_r - 4'd1;
        end
      end
      CMD_ASSERT: begin
        if (mask_r[item.irq_line]) begin
          flag_cmd[item.irq_line] = 1'b1;
        end
      end
      CMD_WRITE: begin
        case (item.reg_offset)
          OFF_RSV00, OFF_RSV05, OFF_RSV28, OFF_RSV29, OFF_RSV2A: begin
          end
          OFF_IMR:  mask_nxt = item.write_data;
          OFF_IFR:  flag_cmd = flag_r & ~item.write_data;
          OFF_PMST: begin
            base_nxt = item.write_data[15:11];
            mode_nxt = {item.write_data[7], item.write_data[5:0]};
          end
          OFF_TIM:  tcnt_nxt   = item.write_data;
          OFF_PRD:  period_nxt = item.write_data;
          OFF_TCR: begin
            reload_nxt = item.write_data[3:0];
            psc_nxt    = item.write_data[9:6];
            if (item.write_data[5]) begin
              tcnt_nxt = period_r;
              psc_nxt  = item.write_data[3:0];
            end
          end
          default: unk = 1'b1;
        endcase
      end
      CMD_READ: begin
        case (item.reg_offset)
          OFF_IMR:  rd = mask_r;
          OFF_IFR:  rd = flag_r;
          OFF_PMST: rd = {base_r, 3'b000, mode_r[6], 1'b0, mode_r[5:0]};
          OFF_TIM:  rd = tcnt_r;
          OFF_PRD:  rd = period_r;
          OFF_TCR:  rd = {6'b000000, psc_r, 2'b00, reload_r};
          OFF_RSV28, OFF_RSV37: rd = '0;
          default:  unk = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  // interrupt take, after the command has acted
  always_comb begin
    flag_nxt        = flag_cmd;
    res             = '0;
    res.read_data   = rd;
    res.reg_unknown = unk;
    if (!item.int_disable && sel.found) begin
      flag_nxt       = flag_cmd & ~(16'd1 << sel.idx);
      res.int_taken  = 1'b1;
      res.int_number = sel.idx;
      res.int_vector = {base_nxt, 5'b00000, ({1'b0, sel.idx} + 5'd1), 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      flag_r   <= '0;
      base_r   <= '0;
      mode_r   <= '0;
      psc_r    <= '0;
      reload_r <= '0;
      tcnt_r   <= '0;
      period_r <= '0;
    end else if (exec) begin
      mask_r   <= mask_nxt;
      flag_r   <= flag_nxt;
      base_r   <= base_nxt;
      mode_r   <= mode_nxt;
      psc_r    <= psc_nxt;
      reload_r <= reload_nxt;
      tcnt_r   <= tcnt_nxt;
      period_r <= period_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/tirb_chk.sv]
// ----------------------------------------------------------------------------
// tirb_chk
// Port-level checks of the timer and interrupt register block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tirb_chk
  import tirb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped or changed while stalled")
  `ASSERT_IMPLY(a_vec_form, out_valid && out_data.int_taken, (out_data.int_vector[5:1] == ({1'b0, out_data.int_number} + 5'd1)) && (out_data.int_vector[10:6] == 5'd0) && !out_data.int_vector[0], "vector does not match taken interrupt")
  `ASSERT_IMPLY(a_no_take, out_valid && !out_data.int_taken, (out_data.int_number == 4'd0) && (out_data.int_vector == 16'd0), "interrupt fields set without a take")
  `ASSERT_IMPLY(a_unk_zero, out_valid && out_data.reg_unknown, out_data.read_data == 16'd0, "unknown offset returned read data")

endmodule

bind timer_interrupt_register_block tirb_chk u_tirb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
